>>> hdl/assert_macros.svh
// Assertion macros used by the contact table sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that holds at every clock edge outside reset.
`define DBCT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dbct assertion failed");

// Implication checked in the same cycle.
`define DBCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dbct implication failed");

`else

`define DBCT_ASSERT(lbl, clk, rst_n, prop)
`define DBCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/dbct_pkg.sv
// Package: sizes, codes and record types of the double-buffered contact table.
`default_nettype none

package dbct_pkg;

    // Entries per bank; the store holds two banks.
    localparam int MAX_CONTACTS = 1024;
    localparam int STORE_DEPTH  = 2 * MAX_CONTACTS;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    // Fill counters must hold MAX_CONTACTS itself.
    localparam int FILL_W       = $clog2(MAX_CONTACTS + 1);

    // Operation codes of the mode field.
    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_SWAP   = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;

    // One stored contact record.
    typedef struct packed {
        logic [63:0]        key;
        logic signed [31:0] status;
        logic [63:0]        x_bits;
        logic [63:0]        y_bits;
        logic [63:0]        z_bits;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    // One result word.
    typedef struct packed {
        logic               accepted;
        logic               found;
        logic signed [31:0] status;
        logic [63:0]        x_bits;
        logic [63:0]        y_bits;
        logic [63:0]        z_bits;
    } t_res;

    // Store address of entry idx in the given bank.
    function automatic logic [ADDR_W-1:0] f_addr(input logic bank,
                                                 input logic [FILL_W-1:0] idx);
        logic [ADDR_W-1:0] base;
        base = bank ? ADDR_W'(MAX_CONTACTS) : '0;
        return base + ADDR_W'(idx);
    endfunction

endpackage

`default_nettype wire

>>> hdl/dbct_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module dbct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic                     i_we,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write, or read with the data held until the next read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/dbct_seq.sv
// Sequencer: decodes items, keeps fill counts and bank select, scans the store.
`default_nettype none
`include "assert_macros.svh"

module dbct_seq (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // input channel
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [1:0]              i_mode,
    input  wire logic [63:0]             i_contact_id,
    input  wire logic signed [31:0]      i_entry_status,
    input  wire logic [63:0]             i_vec_x_bits,
    input  wire logic [63:0]             i_vec_y_bits,
    input  wire logic [63:0]             i_vec_z_bits,
    // record store port
    output logic [dbct_pkg::ADDR_W-1:0]  o_ram_addr,
    output logic                         o_ram_we,
    output dbct_pkg::t_rec               o_ram_wdata,
    output logic                         o_ram_re,
    input  wire dbct_pkg::t_rec          i_ram_rdata,
    // result toward the output stage
    output logic                         o_res_valid,
    output dbct_pkg::t_res               o_res,
    input  wire logic                    i_out_ready
);

    import dbct_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic              r_state, n_state;
    logic              r_bank, n_bank;
    logic [FILL_W-1:0] r_cur_fill, n_cur_fill;
    logic [FILL_W-1:0] r_pend_fill, n_pend_fill;
    logic [FILL_W-1:0] r_rd_idx, n_rd_idx;
    logic [63:0]       r_key, n_key;
    logic              in_acc;
    logic              hit;

    assign o_stall = (r_state != ST_IDLE) || !i_out_ready;
    assign in_acc  = i_valid && !o_stall;
    assign hit     = (i_ram_rdata.key == r_key);

    // Store write data is always the incoming record.
    assign o_ram_wdata = '{key: i_contact_id, status: i_entry_status,
                           x_bits: i_vec_x_bits, y_bits: i_vec_y_bits,
                           z_bits: i_vec_z_bits};

    // Next state, store access and result.
    // Lookups read only the current bank and adds write only the pending
    // bank, so read and write never touch the same entry.
    always_comb begin
        n_state     = r_state;
        n_bank      = r_bank;
        n_cur_fill  = r_cur_fill;
        n_pend_fill = r_pend_fill;
        n_rd_idx    = r_rd_idx;
        n_key       = r_key;
        o_ram_addr  = f_addr(r_bank, r_rd_idx);
        o_ram_we    = 1'b0;
        o_ram_re    = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.accepted = 1'b1;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (i_mode)
                        MODE_ADD: begin
                            o_res_valid = 1'b1;
                            if (r_pend_fill >= FILL_W'(MAX_CONTACTS)) begin
                                o_res.accepted = 1'b0;
                            end else begin
                                o_ram_addr  = f_addr(~r_bank, r_pend_fill);
                                o_ram_we    = 1'b1;
                                n_pend_fill = r_pend_fill + 1'b1;
                            end
                        end
                        MODE_SWAP: begin
                            o_res_valid = 1'b1;
                            n_bank      = ~r_bank;
                            n_cur_fill  = r_pend_fill;
                            n_pend_fill = '0;
                        end
                        MODE_LOOKUP: begin
                            if (r_cur_fill == '0) begin
                                o_res_valid = 1'b1;
                            end else begin
                                // first read goes out with the accept
                                o_ram_addr = f_addr(r_bank, '0);
                                o_ram_re   = 1'b1;
                                n_rd_idx   = FILL_W'(1);
                                n_key      = i_contact_id;
                                n_state    = ST_SCAN;
                            end
                        end
                        default: begin
                            o_res_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // read data holds the entry at r_rd_idx - 1
                if (hit || (r_rd_idx == r_cur_fill)) begin
                    if (i_out_ready) begin
                        o_res_valid = 1'b1;
                        if (hit) begin
                            o_res.found  = 1'b1;
                            o_res.status = i_ram_rdata.status;
                            o_res.x_bits = i_ram_rdata.x_bits;
                            o_res.y_bits = i_ram_rdata.y_bits;
                            o_res.z_bits = i_ram_rdata.z_bits;
                        end
                        n_state = ST_IDLE;
                    end
                end else begin
                    o_ram_re = 1'b1;
                    n_rd_idx = r_rd_idx + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_bank      <= 1'b0;
            r_cur_fill  <= '0;
            r_pend_fill <= '0;
            r_rd_idx    <= '0;
        end else begin
            r_state     <= n_state;
            r_bank      <= n_bank;
            r_cur_fill  <= n_cur_fill;
            r_pend_fill <= n_pend_fill;
            r_rd_idx    <= n_rd_idx;
        end
    end

    // Search key.
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    `DBCT_ASSERT(a_pend_fill_max, i_clk, i_rst_n, r_pend_fill <= FILL_W'(MAX_CONTACTS))
    `DBCT_ASSERT(a_cur_fill_max, i_clk, i_rst_n, r_cur_fill <= FILL_W'(MAX_CONTACTS))
    `DBCT_ASSERT_IMP(a_scan_idx, i_clk, i_rst_n, r_state == ST_SCAN, (r_rd_idx != '0) && (r_rd_idx <= r_cur_fill))
    `DBCT_ASSERT_IMP(a_res_room, i_clk, i_rst_n, o_res_valid, i_out_ready)
    `DBCT_ASSERT_IMP(a_no_rw, i_clk, i_rst_n, o_ram_we, !o_ram_re && (r_state == ST_IDLE))

endmodule

`default_nettype wire

>>> hdl/dbct_out.sv
// Output register stage: holds one result word until the consumer takes it.
`default_nettype none

module dbct_out (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_res_valid,
    input  wire dbct_pkg::t_res  i_res,
    output logic                 o_ready,
    output logic                 o_valid,
    output dbct_pkg::t_res       o_res,
    input  wire logic            i_stall
);

    import dbct_pkg::*;

    logic r_valid;
    t_res r_res;

    // Room when empty or when the held word leaves this cycle.
    assign o_ready = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

>>> hdl/double_buffered_contact_table_top.sv
// Top level of the double-buffered contact table.
//
//  channel  | valid    | stall    | payload
//  ---------+----------+----------+------------------------------------------------
//  input    | i_valid  | o_stall  | i_mode, i_contact_id, i_entry_status, i_vec_*
//  output   | o_valid  | i_stall  | o_accepted, o_found, o_out_status, o_out_*_bits
//
// Add, swap and ignored codes give their result word on acceptance. A lookup
// reads the current bank from entry 0 up to the first hit or the current fill,
// with no scan of an empty bank; the single read port walks one entry per cycle.
// Reset is synchronous, active low; it clears control registers, not the store.
// Input stalls during a scan and while a result word is held under an output
// stall; a held word and a new input word can cross in the same cycle.
`default_nettype none

module double_buffered_contact_table_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_mode,
    input  wire logic [63:0]        i_contact_id,
    input  wire logic signed [31:0] i_entry_status,
    input  wire logic [63:0]        i_vec_x_bits,
    input  wire logic [63:0]        i_vec_y_bits,
    input  wire logic [63:0]        i_vec_z_bits,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_accepted,
    output logic                    o_found,
    output logic signed [31:0]      o_out_status,
    output logic [63:0]             o_out_x_bits,
    output logic [63:0]             o_out_y_bits,
    output logic [63:0]             o_out_z_bits
);

    import dbct_pkg::*;

    logic [ADDR_W-1:0] ram_addr;
    logic              ram_we;
    logic              ram_re;
    t_rec              ram_wdata;
    t_rec              ram_rdata;
    logic [REC_W-1:0]  ram_rdata_raw;
    logic              res_valid;
    t_res              res;
    logic              out_ready;
    t_res              out_res;

    // Both banks of records in one store.
    dbct_ram #(
        .WIDTH (REC_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_addr  (ram_addr),
        .i_we    (ram_we),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .o_rdata (ram_rdata_raw)
    );

    assign ram_rdata = t_rec'(ram_rdata_raw);

    dbct_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_contact_id   (i_contact_id),
        .i_entry_status (i_entry_status),
        .i_vec_x_bits   (i_vec_x_bits),
        .i_vec_y_bits   (i_vec_y_bits),
        .i_vec_z_bits   (i_vec_z_bits),
        .o_ram_addr     (ram_addr),
        .o_ram_we       (ram_we),
        .o_ram_wdata    (ram_wdata),
        .o_ram_re       (ram_re),
        .i_ram_rdata    (ram_rdata),
        .o_res_valid    (res_valid),
        .o_res          (res),
        .i_out_ready    (out_ready)
    );

    dbct_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_ready     (out_ready),
        .o_valid     (o_valid),
        .o_res       (out_res),
        .i_stall     (i_stall)
    );

    // Result word onto the field ports.
    assign o_accepted   = out_res.accepted;
    assign o_found      = out_res.found;
    assign o_out_status = out_res.status;
    assign o_out_x_bits = out_res.x_bits;
    assign o_out_y_bits = out_res.y_bits;
    assign o_out_z_bits = out_res.z_bits;

endmodule

`default_nettype wire

>>> test/double_buffered_contact_table_top_tb.sv
// Self-checking testbench for the double-buffered contact table: directed and random stimulus.
`default_nettype none

module double_buffered_contact_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dbct_pkg::*;

    // The package leaves the fourth code unnamed; the block ignores it
    localparam logic [1:0] MODE_IGNORED = 2'd3;

    // Contact table mirror: predicts one reply per request word and checks replies in order
    class contact_table_sb;
        t_rec  bank_rec [2][MAX_CONTACTS];
        int    cur_fill;
        int    pend_fill;
        bit    cur_bank;
        t_res  expected_replies [$];
        int    errors;
        int    n_adds, n_rejects, n_swaps, n_lookups, n_hits, n_ignored;

        function new();
            cur_fill  = 0;
            pend_fill = 0;
            cur_bank  = 1'b0;
            errors    = 0;
            n_adds = 0; n_rejects = 0; n_swaps = 0;
            n_lookups = 0; n_hits = 0; n_ignored = 0;
        endfunction

        // Apply an accepted request word to the mirror and queue its reply
        function void note_request(logic [1:0] mode, t_rec rec);
            t_res reply;
            reply          = '0;
            reply.accepted = 1'b1;
            case (mode)
                MODE_ADD: begin
                    n_adds++;
                    if (pend_fill >= MAX_CONTACTS) begin
                        reply.accepted = 1'b0;
                        n_rejects++;
                    end else begin
                        bank_rec[!cur_bank][pend_fill] = rec;
                        pend_fill++;
                    end
                end
                MODE_SWAP: begin
                    n_swaps++;
                    cur_bank  = !cur_bank;
                    cur_fill  = pend_fill;
                    pend_fill = 0;
                end
                MODE_LOOKUP: begin
                    n_lookups++;
                    // lowest-indexed match wins
                    for (int i = 0; i < cur_fill; i++) begin
                        if (bank_rec[cur_bank][i].key == rec.key) begin
                            reply.found  = 1'b1;
                            reply.status = bank_rec[cur_bank][i].status;
                            reply.x_bits = bank_rec[cur_bank][i].x_bits;
                            reply.y_bits = bank_rec[cur_bank][i].y_bits;
                            reply.z_bits = bank_rec[cur_bank][i].z_bits;
                            n_hits++;
                            break;
                        end
                    end
                end
                default: n_ignored++;
            endcase
            expected_replies = {expected_replies, reply};
        endfunction

        // Compare an accepted reply word against the oldest prediction
        function void check_reply(t_res got);
            t_res exp;
            if (expected_replies.size() == 0) begin
                $error("reply word with no request outstanding");
                errors++;
                return;
            end
            exp = expected_replies.pop_front();
            if (got.accepted !== exp.accepted) begin
                $error("accepted: expected %0b, got %0b", exp.accepted, got.accepted);
                errors++;
            end
            if (got.found !== exp.found) begin
                $error("found: expected %0b, got %0b", exp.found, got.found);
                errors++;
            end
            if (got.status !== exp.status) begin
                $error("out_status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
            if (got.x_bits !== exp.x_bits) begin
                $error("out_x_bits: expected %h, got %h", exp.x_bits, got.x_bits);
                errors++;
            end
            if (got.y_bits !== exp.y_bits) begin
                $error("out_y_bits: expected %h, got %h", exp.y_bits, got.y_bits);
                errors++;
            end
            if (got.z_bits !== exp.z_bits) begin
                $error("out_z_bits: expected %h, got %h", exp.z_bits, got.z_bits);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_mode;
    logic [63:0]        i_contact_id;
    logic signed [31:0] i_entry_status;
    logic [63:0]        i_vec_x_bits;
    logic [63:0]        i_vec_y_bits;
    logic [63:0]        i_vec_z_bits;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_accepted;
    logic               o_found;
    logic signed [31:0] o_out_status;
    logic [63:0]        o_out_x_bits;
    logic [63:0]        o_out_y_bits;
    logic [63:0]        o_out_z_bits;

    contact_table_sb sb = new();

    // Keys as the stimulus side sees them, in issue order
    logic [63:0] cur_keys  [$];
    logic [63:0] pend_keys [$];
    int          words_sent = 0;
    bit          send_calm  = 1'b0;
    bit          recv_calm  = 1'b0;
    int          stall_left = 0;

    double_buffered_contact_table_top dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle length: mostly short, sometimes long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Request side monitor
    always @(posedge i_clk) begin
        t_rec rec;
        if (i_rst_n && i_valid && !o_stall) begin
            rec.key    = i_contact_id;
            rec.status = i_entry_status;
            rec.x_bits = i_vec_x_bits;
            rec.y_bits = i_vec_y_bits;
            rec.z_bits = i_vec_z_bits;
            sb.note_request(i_mode, rec);
        end
    end

    // Reply side monitor
    always @(posedge i_clk) begin
        t_res got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.accepted = o_accepted;
            got.found    = o_found;
            got.status   = o_out_status;
            got.x_bits   = o_out_x_bits;
            got.y_bits   = o_out_y_bits;
            got.z_bits   = o_out_z_bits;
            sb.check_reply(got);
        end
    end

    // Downstream back-pressure, with calm stretches
    always @(posedge i_clk) begin
        if ($urandom_range(0, 399) == 0)
            recv_calm = !recv_calm;
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
            if (!recv_calm && $urandom_range(0, 99) < 30)
                stall_left = idle_len();
        end
    end

    // Drive one request word and hold it until it is taken
    task automatic send_word(logic [1:0] mode, logic [63:0] key, logic signed [31:0] status,
                             logic [63:0] x, logic [63:0] y, logic [63:0] z);
        int gap;
        gap = send_calm ? 0 : idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_mode         <= mode;
        i_contact_id   <= key;
        i_entry_status <= status;
        i_vec_x_bits   <= x;
        i_vec_y_bits   <= y;
        i_vec_z_bits   <= z;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        // keep the stimulus-side key view in step with the table
        if (mode == MODE_ADD && pend_keys.size() < MAX_CONTACTS)
            pend_keys = {pend_keys, key};
        if (mode == MODE_SWAP) begin
            cur_keys = pend_keys;
            pend_keys.delete();
        end
        if (mode != MODE_IGNORED)
            words_sent++;
    endtask

    task automatic send_add(logic [63:0] key);
        send_word(MODE_ADD, key, $urandom(), rand64(), rand64(), rand64());
    endtask

    task automatic send_op(logic [1:0] mode, logic [63:0] key);
        send_word(mode, key, $urandom(), rand64(), rand64(), rand64());
    endtask

    // Random rounds: adds, lookups and some ignored words interleaved, then a swap
    task automatic run_random_rounds(int n_words);
        int          n_add, n_look, r;
        logic [63:0] key;
        while (words_sent < n_words) begin
            if ($urandom_range(0, 5) == 0)
                send_calm = !send_calm;
            n_add  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
            n_look = $urandom_range(1, 12);
            while (n_add + n_look > 0) begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    send_op(MODE_IGNORED, rand64());
                end else if (n_add > 0 && (r < 55 || n_look == 0)) begin
                    r = $urandom_range(0, 99);
                    if (r < 25 && pend_keys.size() > 0)
                        key = pend_keys[$urandom_range(0, pend_keys.size() - 1)];
                    else if (r < 28)
                        key = '0;
                    else if (r < 31)
                        key = '1;
                    else
                        key = rand64();
                    send_add(key);
                    n_add--;
                end else if (n_look > 0) begin
                    r = $urandom_range(0, 99);
                    if (r < 55 && cur_keys.size() > 0)
                        key = cur_keys[$urandom_range(0, cur_keys.size() - 1)];
                    else if (r < 70 && pend_keys.size() > 0)
                        key = pend_keys[$urandom_range(0, pend_keys.size() - 1)];
                    else
                        key = rand64();
                    send_op(MODE_LOOKUP, key);
                    n_look--;
                end
            end
            send_op(MODE_SWAP, rand64());
            // now and then a second swap empties the current bank
            if ($urandom_range(0, 19) == 0)
                send_op(MODE_SWAP, rand64());
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_mode         = MODE_ADD;
        i_contact_id   = '0;
        i_entry_status = '0;
        i_vec_x_bits   = '0;
        i_vec_y_bits   = '0;
        i_vec_z_bits   = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty bank, ignored code, field extremes, duplicates
        send_op(MODE_LOOKUP, '0);
        send_op(MODE_SWAP, '0);
        send_op(MODE_LOOKUP, '1);
        send_word(MODE_IGNORED, '1, '1, '1, '1, '1);
        send_word(MODE_ADD, '0, '0, '0, '0, '0);
        send_word(MODE_ADD, '1, 32'sh8000_0000, '1, '1, '1);
        send_word(MODE_ADD, 64'h8000_0000_0000_0001, 32'sh7fff_ffff,
                  64'h7ff0_0000_0000_0000, 64'hfff8_0000_0000_0000, 64'h8000_0000_0000_0000);
        send_word(MODE_ADD, '1, 32'sh1234_5678, 64'h1, 64'h2, 64'h3);
        send_op(MODE_LOOKUP, '1);
        send_op(MODE_SWAP, '0);
        send_op(MODE_LOOKUP, '0);
        send_op(MODE_LOOKUP, '1);
        send_op(MODE_LOOKUP, 64'h8000_0000_0000_0001);
        send_op(MODE_LOOKUP, 64'h0000_0000_0000_0001);
        send_word(MODE_IGNORED, '0, '0, '0, '0, '0);
        send_op(MODE_LOOKUP, '0);
        send_op(MODE_SWAP, '1);
        send_op(MODE_LOOKUP, '0);

        run_random_rounds(580);
        i_valid <= 1'b0;

        // let the monitor note the last word before draining
        @(posedge i_clk);
        while (sb.expected_replies.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Ran %0d words: %0d adds (%0d rejected), %0d swaps, %0d lookups",
                 words_sent, sb.n_adds, sb.n_rejects, sb.n_swaps, sb.n_lookups);
        $display("Lookup hits: %0d, ignored words: %0d, mismatches: %0d",
                 sb.n_hits, sb.n_ignored, sb.errors);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #30_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
